// ----- design/pbfm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pbfm_pkg;

  // Number of frames in the pool and the widths that follow from it.
  localparam int FRAMES = 16;
  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int PAGE_W = 32;
  localparam int PIN_W  = 8;

  localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

  // Request kinds; the fourth code is unused and completes with no change.
  localparam logic [1:0] REQ_FETCH = 2'd0;
  localparam logic [1:0] REQ_UNPIN = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_HIT        = 3'd0;
  localparam logic [2:0] ST_MISS       = 3'd1;
  localparam logic [2:0] ST_ALL_PINNED = 3'd2;
  localparam logic [2:0] ST_DONE_OK    = 3'd3;
  localparam logic [2:0] ST_ABSENT     = 3'd4;

  // Sequencer states.
  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SCAN    = 8'b0000_0010,
    S_DECIDE  = 8'b0000_0100,
    S_INSTALL = 8'b0000_1000,
    S_LSCAN   = 8'b0001_0000,
    S_SHIFT   = 8'b0010_0000,
    S_APPEND  = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } seq_state_t;

endpackage

`default_nettype wire

// ----- design/page_buffer_frame_manager_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Page-to-frame map of a buffer pool with least-recently-unpinned replacement.
// Requests arrive on the in_ stream: in_tuser carries the request kind (fetch,
// unpin, flush) and in_tdata the page id and the dirty flag. Every request
// yields exactly one result on the out_ stream: out_tuser carries the status,
// out_tdata the frame index, the write-back flag and page, and the read flag.
// One compare unit walks the frame table one frame per cycle to find the page,
// and walks the recency list one entry per cycle to find the frame's position.
// The two table walks set how long a request takes from acceptance until its
// result is loaded into the output register; an unpin or flush found in frame
// 0 with no list change takes the least. Only one request is in work at a
// time, and the next one can be accepted in the cycle after a result is loaded.
// in_tready is high while the sequencer is idle, even while an earlier result
// waits in the output register. When the receiver stalls, the finished result
// is held in an internal result register until the output register frees up,
// and no new request is taken.
// Reset clears the valid, dirty and pin state, the recency list length and
// the next-unused counter; page ids and list entries are written before read.
module page_buffer_frame_manager_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [31:0] page_id, [32] set_dirty, rest zero
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [3:0] frame_index, [4] write_back,
                                       // [36:5] write_back_page, [37] read_needed
  output logic [2:0]       out_tuser   // [2:0] status
);

  localparam logic [pbfm_pkg::FIDX_W-1:0] LAST_IDX =
    pbfm_pkg::FIDX_W'(pbfm_pkg::FRAMES - 1);
  localparam logic [pbfm_pkg::CNT_W-1:0] FRAMES_CNT =
    pbfm_pkg::CNT_W'(pbfm_pkg::FRAMES);

  pbfm_pkg::seq_state_t state_r;

  // Frame table.
  logic [pbfm_pkg::PAGE_W-1:0] page_mem [pbfm_pkg::FRAMES];
  logic [pbfm_pkg::FRAMES-1:0] valid_r;
  logic [pbfm_pkg::FRAMES-1:0] dirty_r;
  logic [pbfm_pkg::PIN_W-1:0]  pins_r [pbfm_pkg::FRAMES];

  // Recency list, oldest first, and its length.
  logic [pbfm_pkg::FIDX_W-1:0] rec_list [pbfm_pkg::FRAMES];
  logic [pbfm_pkg::CNT_W-1:0]  rec_len_r;
  logic [pbfm_pkg::CNT_W-1:0]  next_unused_r;

  // Latched request and working registers.
  logic [1:0]                  req_r;
  logic [pbfm_pkg::PAGE_W-1:0] page_r;
  logic                        set_dirty_r;
  logic [pbfm_pkg::FIDX_W-1:0] idx_r;
  logic [pbfm_pkg::FIDX_W-1:0] frame_r;
  logic [pbfm_pkg::FIDX_W-1:0] pos_r;
  logic                        found_r;
  logic                        touch_r;

  // Finished result waiting for the output register.
  logic [2:0]                  res_status_r;
  logic [3:0]                  res_fidx_r;
  logic                        res_wb_r;
  logic [pbfm_pkg::PAGE_W-1:0] res_wbp_r;
  logic                        res_rd_r;

  // Output register.
  logic                        out_valid_r;
  logic [2:0]                  out_status_r;
  logic [3:0]                  out_fidx_r;
  logic                        out_wb_r;
  logic [pbfm_pkg::PAGE_W-1:0] out_wbp_r;
  logic                        out_rd_r;

  logic                        in_fire;
  logic                        out_load;
  logic [pbfm_pkg::PAGE_W-1:0] page_rd;
  logic                        page_hit;
  logic                        list_in_range;
  logic                        list_hit;
  logic [pbfm_pkg::PIN_W-1:0]  pins_cur;
  logic [pbfm_pkg::PIN_W-1:0]  pins_dec;
  logic                        evict;
  logic                        shift_en;
  logic [pbfm_pkg::FIDX_W-1:0] shift_pos;
  logic                        fill_en;

  assign in_tready = (state_r == pbfm_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == pbfm_pkg::S_DONE) && (!out_valid_r || out_tready);

  // The shared compare unit: one frame-table entry or one list entry a cycle.
  assign page_rd       = page_mem[idx_r];
  assign page_hit      = valid_r[idx_r] && (page_rd == page_r);
  assign list_in_range = pbfm_pkg::CNT_W'(idx_r) < rec_len_r;
  assign list_hit      = list_in_range && (rec_list[idx_r] == frame_r);

  assign pins_cur = pins_r[frame_r];
  assign pins_dec = (pins_cur != '0) ? pins_cur - 1'b1 : '0;

  // A miss with every frame used takes the head of the recency list, if any.
  assign evict = (state_r == pbfm_pkg::S_DECIDE) && (req_r == pbfm_pkg::REQ_FETCH) &&
                 !found_r && (next_unused_r >= FRAMES_CNT) && (rec_len_r != '0);

  assign shift_en  = evict || (state_r == pbfm_pkg::S_SHIFT);
  assign shift_pos = (state_r == pbfm_pkg::S_SHIFT) ? pos_r : '0;
  assign fill_en   = (state_r == pbfm_pkg::S_SHIFT) && touch_r;

  // Page ids: written only on install.
  always_ff @(posedge clk) begin
    if (state_r == pbfm_pkg::S_INSTALL) begin
      page_mem[idx_r] <= page_r;
    end
  end

  // Recency list entries. Removal shifts every later entry down at once; a
  // re-touch that found the frame in the list puts it back at the young end.
  always_ff @(posedge clk) begin
    for (int j = 0; j < pbfm_pkg::FRAMES; j++) begin
      if (fill_en && (pbfm_pkg::CNT_W'(j) == rec_len_r - 1'b1)) begin
        rec_list[j] <= frame_r;
      end else if (shift_en && (j < pbfm_pkg::FRAMES - 1) &&
                   (pbfm_pkg::FIDX_W'(j) >= shift_pos) &&
                   (pbfm_pkg::CNT_W'(j + 1) < rec_len_r)) begin
        rec_list[j] <= rec_list[(j < pbfm_pkg::FRAMES - 1) ? j + 1 : j];
      end
    end
    if ((state_r == pbfm_pkg::S_APPEND) && (rec_len_r < FRAMES_CNT)) begin
      rec_list[rec_len_r[pbfm_pkg::FIDX_W-1:0]] <= frame_r;
    end
  end

  // Request latch and result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r        <= in_tuser;
      page_r       <= in_tdata[31:0];
      set_dirty_r  <= in_tdata[32];
      res_status_r <= pbfm_pkg::ST_DONE_OK;
      res_fidx_r   <= '0;
      res_wb_r     <= 1'b0;
      res_wbp_r    <= '0;
      res_rd_r     <= 1'b0;
    end
    if ((state_r == pbfm_pkg::S_SCAN) && page_hit) begin
      frame_r <= idx_r;
    end
    if ((state_r == pbfm_pkg::S_LSCAN) && list_hit) begin
      pos_r <= idx_r;
    end
    if (state_r == pbfm_pkg::S_DECIDE) begin
      touch_r <= (req_r == pbfm_pkg::REQ_UNPIN);
      priority if (req_r == pbfm_pkg::REQ_FETCH && found_r) begin
        res_status_r <= pbfm_pkg::ST_HIT;
        res_fidx_r   <= 4'(frame_r);
      end else if (req_r == pbfm_pkg::REQ_FETCH) begin
        if (next_unused_r >= FRAMES_CNT && rec_len_r == '0) begin
          res_status_r <= pbfm_pkg::ST_ALL_PINNED;
        end
      end else if (req_r == pbfm_pkg::REQ_UNPIN || req_r == pbfm_pkg::REQ_FLUSH) begin
        if (!found_r) begin
          res_status_r <= pbfm_pkg::ST_ABSENT;
        end else begin
          res_fidx_r <= 4'(frame_r);
          if (req_r == pbfm_pkg::REQ_FLUSH && dirty_r[frame_r]) begin
            res_wb_r  <= 1'b1;
            res_wbp_r <= page_r;
          end
        end
      end else begin
        // The unused request code keeps the default done result.
      end
    end
    if (state_r == pbfm_pkg::S_INSTALL) begin
      res_status_r <= pbfm_pkg::ST_MISS;
      res_fidx_r   <= 4'(idx_r);
      res_rd_r     <= 1'b1;
      if (valid_r[idx_r] && dirty_r[idx_r]) begin
        res_wb_r  <= 1'b1;
        res_wbp_r <= page_rd;
      end
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_fidx_r   <= res_fidx_r;
      out_wb_r     <= res_wb_r;
      out_wbp_r    <= res_wbp_r;
      out_rd_r     <= res_rd_r;
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pbfm_pkg::S_IDLE;
      valid_r       <= '0;
      dirty_r       <= '0;
      rec_len_r     <= '0;
      next_unused_r <= '0;
      out_valid_r   <= 1'b0;
      idx_r         <= '0;
      found_r       <= 1'b0;
      for (int j = 0; j < pbfm_pkg::FRAMES; j++) begin
        pins_r[j] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        pbfm_pkg::S_IDLE: begin
          if (in_fire) begin
            idx_r   <= '0;
            found_r <= 1'b0;
            state_r <= pbfm_pkg::S_SCAN;
          end
        end
        pbfm_pkg::S_SCAN: begin
          if (page_hit) begin
            found_r <= 1'b1;
            state_r <= pbfm_pkg::S_DECIDE;
          end else if (idx_r == LAST_IDX) begin
            state_r <= pbfm_pkg::S_DECIDE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        pbfm_pkg::S_DECIDE: begin
          priority if (req_r == pbfm_pkg::REQ_FETCH && found_r) begin
            if (pins_cur != pbfm_pkg::PIN_MAX) begin
              pins_r[frame_r] <= pins_cur + 1'b1;
            end
            idx_r   <= '0;
            state_r <= pbfm_pkg::S_LSCAN;
          end else if (req_r == pbfm_pkg::REQ_FETCH) begin
            if (next_unused_r < FRAMES_CNT) begin
              idx_r         <= next_unused_r[pbfm_pkg::FIDX_W-1:0];
              next_unused_r <= next_unused_r + 1'b1;
              state_r       <= pbfm_pkg::S_INSTALL;
            end else if (evict) begin
              idx_r     <= rec_list[0];
              rec_len_r <= rec_len_r - 1'b1;
              state_r   <= pbfm_pkg::S_INSTALL;
            end else begin
              state_r <= pbfm_pkg::S_DONE;
            end
          end else if (req_r == pbfm_pkg::REQ_UNPIN && found_r) begin
            if (set_dirty_r) begin
              dirty_r[frame_r] <= 1'b1;
            end
            pins_r[frame_r] <= pins_dec;
            idx_r           <= '0;
            state_r         <= (pins_dec == '0) ? pbfm_pkg::S_LSCAN : pbfm_pkg::S_DONE;
          end else if (req_r == pbfm_pkg::REQ_FLUSH && found_r) begin
            dirty_r[frame_r] <= 1'b0;
            state_r          <= pbfm_pkg::S_DONE;
          end else begin
            // Absent page or unused request code: nothing changes.
            state_r <= pbfm_pkg::S_DONE;
          end
        end
        pbfm_pkg::S_INSTALL: begin
          dirty_r[idx_r] <= 1'b0;
          valid_r[idx_r] <= 1'b1;
          pins_r[idx_r]  <= pbfm_pkg::PIN_W'(1);
          state_r        <= pbfm_pkg::S_DONE;
        end
        pbfm_pkg::S_LSCAN: begin
          if (list_hit) begin
            state_r <= pbfm_pkg::S_SHIFT;
          end else if (!list_in_range || idx_r == LAST_IDX) begin
            state_r <= touch_r ? pbfm_pkg::S_APPEND : pbfm_pkg::S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        pbfm_pkg::S_SHIFT: begin
          // A re-touch keeps the length: the frame moves to the young end.
          if (!touch_r) begin
            rec_len_r <= rec_len_r - 1'b1;
          end
          state_r <= pbfm_pkg::S_DONE;
        end
        pbfm_pkg::S_APPEND: begin
          if (rec_len_r < FRAMES_CNT) begin
            rec_len_r <= rec_len_r + 1'b1;
          end
          state_r <= pbfm_pkg::S_DONE;
        end
        pbfm_pkg::S_DONE: begin
          if (out_load) begin
            state_r <= pbfm_pkg::S_IDLE;
          end
        end
        default: begin
          state_r <= pbfm_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_rd_r, out_wbp_r, out_wb_r, out_fidx_r};

  // The recency list never holds more entries than there are frames.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rec_len_r <= FRAMES_CNT)
    else $error("recency list length exceeds frame count");

  // The never-used frame counter stops at the frame count.
  a_unused_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_unused_r <= FRAMES_CNT)
    else $error("next unused frame counter overran");

  // A result appears only as the sequencer leaves its final state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == pbfm_pkg::S_DONE))
    else $error("result raised outside the completion state");

  // An accepted request blocks the next one until its work is done.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second request accepted while one is in work");

  // An installed frame is valid and pinned once right after install.
  a_install: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pbfm_pkg::S_INSTALL) |=>
      (valid_r[$past(idx_r)] && pins_r[$past(idx_r)] == pbfm_pkg::PIN_W'(1)))
    else $error("installed frame not valid or not pinned");

endmodule

`default_nettype wire

// ----- sim/frame_map_checker.sv -----
`timescale 1ns / 1ps

module frame_map_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [2:0]  out_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [2:0]                  status;
    logic [pbfm_pkg::FIDX_W-1:0] fidx;
    logic                        wb;
    logic [pbfm_pkg::PAGE_W-1:0] wbp;
    logic                        rd;
  } frame_result_t;

  logic [pbfm_pkg::PAGE_W-1:0] page_in_frame [pbfm_pkg::FRAMES];
  logic                        frame_used [pbfm_pkg::FRAMES];
  logic                        frame_modified [pbfm_pkg::FRAMES];
  logic [pbfm_pkg::PIN_W-1:0]  pin_count [pbfm_pkg::FRAMES];
  int unsigned                 unpinned_order [$];
  int unsigned                 next_fresh;
  frame_result_t               expected_results [$];
  int                          errors = 0;

  function automatic int lookup_frame(input logic [pbfm_pkg::PAGE_W-1:0] page);
    for (int i = 0; i < pbfm_pkg::FRAMES; i++) begin
      if (frame_used[i] && page_in_frame[i] == page) return i;
    end
    return -1;
  endfunction

  function automatic void drop_from_order(input int unsigned frame);
    for (int k = 0; k < unpinned_order.size(); k++) begin
      if (unpinned_order[k] == frame) begin
        unpinned_order.delete(k);
        return;
      end
    end
  endfunction

  // Applies one request to the mirrored pool and returns the result it must produce.
  function automatic frame_result_t predict_request(input logic [1:0] kind,
                                                    input logic [pbfm_pkg::PAGE_W-1:0] page,
                                                    input logic dirty);
    frame_result_t res;
    int            f;
    int unsigned   v;
    bit            have_victim;
    res = '0;
    res.status = pbfm_pkg::ST_DONE_OK;
    f = lookup_frame(page);
    case (kind)
      pbfm_pkg::REQ_FETCH: begin
        if (f >= 0) begin
          if (pin_count[f] != pbfm_pkg::PIN_MAX) pin_count[f]++;
          drop_from_order(f);
          res.status = pbfm_pkg::ST_HIT;
          res.fidx = f[pbfm_pkg::FIDX_W-1:0];
        end else begin
          have_victim = 1'b1;
          v = 0;
          if (next_fresh < pbfm_pkg::FRAMES) begin
            v = next_fresh;
            next_fresh++;
          end else if (unpinned_order.size() != 0) begin
            v = unpinned_order[0];
            unpinned_order.delete(0);
          end else begin
            have_victim = 1'b0;
          end
          if (!have_victim) begin
            res.status = pbfm_pkg::ST_ALL_PINNED;
          end else begin
            if (frame_used[v] && frame_modified[v]) begin
              res.wb = 1'b1;
              res.wbp = page_in_frame[v];
            end
            frame_modified[v] = 1'b0;
            frame_used[v] = 1'b1;
            page_in_frame[v] = page;
            pin_count[v] = 1;
            res.status = pbfm_pkg::ST_MISS;
            res.fidx = v[pbfm_pkg::FIDX_W-1:0];
            res.rd = 1'b1;
          end
        end
      end
      pbfm_pkg::REQ_UNPIN, pbfm_pkg::REQ_FLUSH: begin
        if (f < 0) begin
          res.status = pbfm_pkg::ST_ABSENT;
        end else if (kind == pbfm_pkg::REQ_UNPIN) begin
          if (dirty) frame_modified[f] = 1'b1;
          if (pin_count[f] != 0) pin_count[f]--;
          if (pin_count[f] == 0) begin
            drop_from_order(f);
            unpinned_order.insert(unpinned_order.size(), f);
          end
          res.fidx = f[pbfm_pkg::FIDX_W-1:0];
        end else begin
          if (frame_modified[f]) begin
            res.wb = 1'b1;
            res.wbp = page;
            frame_modified[f] = 1'b0;
          end
          res.fidx = f[pbfm_pkg::FIDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Results are compared before the new request is queued so that a stray
  // result can never be matched against a request taken at the same edge.
  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    frame_result_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < pbfm_pkg::FRAMES; i++) begin
        frame_used[i] = 1'b0;
        frame_modified[i] = 1'b0;
        pin_count[i] = '0;
        page_in_frame[i] = '0;
      end
      unpinned_order.delete();
      expected_results.delete();
      next_fresh = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.fidx = out_tdata[3:0];
        got.wb = out_tdata[4];
        got.wbp = out_tdata[36:5];
        got.rd = out_tdata[37];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with no request waiting, expected none actual status %0d",
                   $time, got.status);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          check_field("status", want.status, got.status);
          check_field("frame_index", want.fidx, got.fidx);
          check_field("write_back", want.wb, got.wb);
          check_field("write_back_page", want.wbp, got.wbp);
          check_field("read_needed", want.rd, got.rd);
        end
      end
      if (in_tvalid && in_tready) begin
        fresh = predict_request(in_tuser, in_tdata[31:0], in_tdata[32]);
        expected_results.insert(expected_results.size(), fresh);
      end
    end
    fail_count <= errors;
    pending <= expected_results.size();
  end

endmodule

// ----- sim/page_buffer_frame_manager_top_tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the buffer pool frame manager. The checker beside
// the block mirrors the pool and compares every result; this module only
// generates requests, shapes the handshakes and reports the outcome.
module page_buffer_frame_manager_top_tb;

  // The fourth request code is not a real operation; the block must finish it
  // without touching any state.
  localparam logic [1:0] REQ_SPARE = 2'd3;

  localparam int TOTAL_REQS   = 1850;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 2 * pbfm_pkg::FRAMES + 24;
  localparam int POOL_PAGES   = 24;
  localparam int HOLD_CYCLES  = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  int          fail_count;
  int          pending;

  // Set by the stimulus once; the receiver answers it with one long stall.
  logic        hold_off_req = 1'b0;
  int          burst_left = 0;
  int          issued = 0;
  // Pages the stimulus has fetched and not yet unpinned, one entry per pin.
  logic [31:0] pinned_pages [$];
  // Small working set, a bit larger than the pool, so that hits and evictions
  // both happen often.
  logic [31:0] page_pool [POOL_PAGES];

  initial begin
    forever #2 clk = ~clk;
  end

  page_buffer_frame_manager_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  frame_map_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // The receiver moves among stall patterns chosen at random: always ready,
  // a fixed duty cycle, and light or heavy random stalls. The
  // one long hold lets the output register and the internal result register
  // both fill so that the block must drop in_tready.
  initial begin : receiver
    int  cyc;
    int  mode;
    bit  hold_done;
    cyc = 0;
    mode = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= (cyc % 3) != 0;
          2: out_tready <= $urandom_range(0, 9) < 7;
          default: out_tready <= $urandom_range(0, 9) < 2;
        endcase
        cyc++;
        if (cyc % 300 == 0) mode = $urandom_range(0, 3);
      end
    end
  end

  // Offers one request and returns at the edge where it is accepted. Requests
  // go out in bursts; a random gap precedes each new burst, and now and then
  // a long burst runs with no gaps at all.
  task automatic send_req(input logic [1:0] kind, input logic [31:0] page,
                          input logic dirty);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {7'd0, dirty, page};
    do @(posedge clk); while (!in_tready);
    issued++;
  endtask

  // Same as send_req, but keeps the list of pins held by the stimulus so that
  // most unpins later name a page that is really pinned.
  task automatic issue(input logic [1:0] kind, input logic [31:0] page, input logic dirty);
    send_req(kind, page, dirty);
    if (kind == pbfm_pkg::REQ_FETCH) begin
      pinned_pages.insert(pinned_pages.size(), page);
    end else if (kind == pbfm_pkg::REQ_UNPIN) begin
      for (int k = 0; k < pinned_pages.size(); k++) begin
        if (pinned_pages[k] == page) begin
          pinned_pages.delete(k);
          break;
        end
      end
    end
  endtask

  // Stops offering and waits until the checker has seen every result.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Releases every pin the stimulus still holds.
  task automatic release_all();
    while (pinned_pages.size() != 0) begin
      issue(pbfm_pkg::REQ_UNPIN, pinned_pages[0], 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stimulus
    int          r;
    int          k;
    int          cap;
    bit          hammered;
    bit          paused;
    logic [31:0] hot_page;
    cap = 14;
    hammered = 1'b0;
    paused = 1'b0;
    page_pool[0] = 32'h0000_0000;
    page_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_PAGES; i++) page_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Unpin and flush of a page that is not resident, then the
    // spare request code on an empty pool.
    issue(pbfm_pkg::REQ_UNPIN, 32'h1234_5678, 1'b1);
    issue(pbfm_pkg::REQ_FLUSH, 32'h1234_5678, 1'b0);
    issue(REQ_SPARE, 32'hDEAD_BEEF, 1'b1);
    // Two misses into fresh frames with the extreme page ids, then a hit.
    issue(pbfm_pkg::REQ_FETCH, 32'h0000_0000, 1'b0);
    issue(pbfm_pkg::REQ_FETCH, 32'hFFFF_FFFF, 1'b1);
    issue(pbfm_pkg::REQ_FETCH, 32'h0000_0000, 1'b0);
    // Unpin down to zero with the dirty flag, then once more at zero pins,
    // which still moves the frame to the recent end of the list.
    issue(pbfm_pkg::REQ_UNPIN, 32'h0000_0000, 1'b1);
    issue(pbfm_pkg::REQ_UNPIN, 32'h0000_0000, 1'b0);
    issue(pbfm_pkg::REQ_UNPIN, 32'h0000_0000, 1'b0);
    // A flush of a dirty page reports the write-back; a second one does not.
    issue(pbfm_pkg::REQ_FLUSH, 32'h0000_0000, 1'b0);
    issue(pbfm_pkg::REQ_FLUSH, 32'h0000_0000, 1'b1);
    issue(pbfm_pkg::REQ_UNPIN, 32'hFFFF_FFFF, 1'b1);
    // Use up every fresh frame.
    for (int i = 2; i < pbfm_pkg::FRAMES; i++) begin
      issue(pbfm_pkg::REQ_FETCH, 32'h0000_0100 + i, 1'b0);
    end
    // Evict the clean oldest frame, then the dirty one with its write-back,
    // then find every frame pinned.
    issue(pbfm_pkg::REQ_FETCH, 32'h5555_AAAA, 1'b0);
    issue(pbfm_pkg::REQ_FETCH, 32'hAAAA_5555, 1'b0);
    issue(pbfm_pkg::REQ_FETCH, 32'h0F0F_F0F0, 1'b1);
    wait_drained();
    release_all();

    // Random part: mostly fetch and unpin pairs over the working set, with
    // flushes, stray unpins, the spare code and pages outside the set mixed in.
    while (issued < TOTAL_REQS) begin
      if ($urandom_range(0, 149) == 0) cap = $urandom_range(10, 18);

      // One page is fetched past the pin limit, then unpinned down past zero.
      if (!hammered && issued >= 600) begin
        release_all();
        hot_page = $urandom;
        repeat (pbfm_pkg::PIN_MAX + 5) begin
          send_req(pbfm_pkg::REQ_FETCH, hot_page, 1'($urandom_range(0, 1)));
        end
        repeat (pbfm_pkg::PIN_MAX + 1) begin
          send_req(pbfm_pkg::REQ_UNPIN, hot_page, 1'($urandom_range(0, 1)));
        end
        hammered = 1'b1;
      end

      // Ask for the long receiver stall and keep offering requests through it.
      if (!hold_off_req && issued >= 1000) begin
        hold_off_req <= 1'b1;
        burst_left = 64;
      end

      if (!paused && issued >= 1400) begin
        wait_drained();
        paused = 1'b1;
      end

      r = $urandom_range(0, 99);
      if (pinned_pages.size() != 0 && (pinned_pages.size() >= cap || r < 38)) begin
        k = $urandom_range(0, pinned_pages.size() - 1);
        issue(pbfm_pkg::REQ_UNPIN, pinned_pages[k], 1'($urandom_range(0, 1)));
      end else if (r < 74) begin
        issue(pbfm_pkg::REQ_FETCH, page_pool[$urandom_range(0, POOL_PAGES - 1)],
              1'($urandom_range(0, 1)));
      end else if (r < 84) begin
        issue(pbfm_pkg::REQ_FLUSH, page_pool[$urandom_range(0, POOL_PAGES - 1)],
              1'($urandom_range(0, 1)));
      end else if (r < 91) begin
        issue(pbfm_pkg::REQ_UNPIN, page_pool[$urandom_range(0, POOL_PAGES - 1)],
              1'($urandom_range(0, 1)));
      end else if (r < 94) begin
        issue(REQ_SPARE, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        issue(pbfm_pkg::REQ_FETCH, $urandom, 1'($urandom_range(0, 1)));
      end
    end

    wait_drained();
    // Leave room for a late stray result before giving the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("page_buffer_frame_manager_top verification clean");
    end else begin
      $display("page_buffer_frame_manager_top verification failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("page_buffer_frame_manager_top verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pbfm_pkg.sv
design/page_buffer_frame_manager_top.sv
sim/frame_map_checker.sv
sim/page_buffer_frame_manager_top_tb.sv
